[rtl/oct_pkg.sv]
// ----------------------------------------------------------------------------
// oct_pkg: shared types and constants of the overcurrent trip block
// Field widths, action and register codes, reset values, and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package oct_pkg;

  // default geometry
  localparam int DEF_CONTROLLERS = 4;
  localparam int DEF_CHANNELS    = 4;
  localparam int MAX_RESULTS     = 4;

  // field widths
  localparam int ACT_W      = 2;
  localparam int CTRL_FW    = 2;
  localparam int CH_FW      = 2;
  localparam int MV_W       = 12;
  localparam int SLOT_W     = 3;
  localparam int CMD_W      = 8;
  localparam int EN_W       = 4;
  localparam int DLY_W      = 16;
  localparam int NUM_THR    = 4;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // input actions
  localparam logic [ACT_W-1:0] ACT_CHECK = 2'd0;
  localparam logic [ACT_W-1:0] ACT_TICK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_SCAN  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_THR0  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THR1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR3  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY = 3'd4;

  // constants and reset values
  localparam logic [CMD_W-1:0] CMD_BASE  = 8'h80;
  localparam logic [EN_W-1:0]  EN_ALL    = 4'hF;
  localparam logic [DLY_W-1:0] MS_MAX    = 16'hFFFF;
  localparam logic [MV_W-1:0]  THR0_RST  = 12'd200;
  localparam logic [MV_W-1:0]  THR1_RST  = 12'd200;
  localparam logic [MV_W-1:0]  THR2_RST  = 12'd300;
  localparam logic [MV_W-1:0]  THR3_RST  = 12'd500;
  localparam logic [DLY_W-1:0] DELAY_RST = 16'd5000;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch input transaction
    logic tick;        // advance ms counter
    logic scan_start;  // arm, start retry if due
    logic chk_commit;  // finish a check transaction
    logic scan_step;   // one stored sample of the retry walk
    logic emit;        // retry command for current controller
  } oct_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_ok;
    logic trip_hit;
    logic retry_due;
    logic ch_last;
    logic ctrl_last;
    logic slot_free;
  } oct_sts_t;

endpackage

[rtl/overcurrent_trip_auto_retry.sv]
// ----------------------------------------------------------------------------
// overcurrent_trip_auto_retry: electronic fuse with overcurrent trip and retry
// Guards CONTROLLERS switch controllers of CHANNELS channels each, emits
// output-register commands on a trip and on a timed retry.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake            Payload
// in_      in   in_tvalid/in_tready  tuser: action; tdata: controller, channel,
//                                    current_mv
// out_     out  out_tvalid/out_tready tdata: frame_slot, command_byte;
//                                    tlast: last command of the transaction
// cfg_     in   cfg_we               cfg_index selects register, cfg_wdata
//
// Tick, end of scan without retry, unknown action and out-of-range checks
// complete in the idle state; a check goes on to a commit step. An end of
// scan that retries walks min(CONTROLLERS,4) controllers: the walk reads one
// stored sample per cycle through a single compare, then loads a command per
// controller. A stalled output register holds a tripping check or the command
// step until out_tready frees it; input is taken only between transactions.
// Reset (synchronous, rst_n low) restores thresholds, enables and samples.
//
module overcurrent_trip_auto_retry import oct_pkg::*; #(
  parameter int CONTROLLERS = DEF_CONTROLLERS,
  parameter int CHANNELS    = DEF_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // input transactions
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // [1:0] controller, [3:2] channel,
                                            // [15:4] current_mv
  input  logic [ACT_W-1:0]      in_tuser,   // [1:0] action
  // result transactions
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] frame_slot,
                                            // [10:3] command_byte, rest zero
  output logic                  out_tlast
);

  oct_cmd_t cmd;
  oct_sts_t sts;

  // sequencing: decode, check commit, retry walk
  oct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_action (in_tuser),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // state, compares and the output register
  oct_dp #(
    .CONTROLLERS (CONTROLLERS),
    .CHANNELS    (CHANNELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[rtl/oct_ctrl.sv]
// ----------------------------------------------------------------------------
// oct_ctrl: sequencing state machine
// Decodes actions, orders the check commit and the retry walk, and waits for
// the output register before loading a command.
// ----------------------------------------------------------------------------
module oct_ctrl import oct_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic [ACT_W-1:0] in_action,
  output logic             in_tready,
  input  oct_sts_t         sts,
  output oct_cmd_t         cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CHECK = 4'b0010,
    S_SCAN  = 4'b0100,
    S_EMIT  = 4'b1000
  } oct_state_t;

  oct_state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          case (in_action)
            ACT_CHECK: begin
              if (sts.idx_ok) state_nxt = S_CHECK;
            end
            ACT_TICK: cmd.tick = 1'b1;
            ACT_SCAN: begin
              cmd.scan_start = 1'b1;
              if (sts.retry_due) state_nxt = S_SCAN;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        // a trip needs the output slot, a plain store does not
        if (!sts.trip_hit || sts.slot_free) begin
          cmd.chk_commit = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.ch_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.ctrl_last ? S_IDLE : S_SCAN;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/oct_dp.sv]
// ----------------------------------------------------------------------------
// oct_dp: fuse datapath
// Thresholds, sample store, channel enables, trip timer and the output
// command register.
// ----------------------------------------------------------------------------
module oct_dp import oct_pkg::*; #(
  parameter int CONTROLLERS = DEF_CONTROLLERS,
  parameter int CHANNELS    = DEF_CHANNELS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast,
  input  oct_cmd_t              cmd,
  output oct_sts_t              sts
);

  localparam int CTRL_W    = (CONTROLLERS > 1) ? $clog2(CONTROLLERS) : 1;
  localparam int CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int RETRY_CNT = (CONTROLLERS < MAX_RESULTS) ? CONTROLLERS : MAX_RESULTS;
  localparam int RC_W      = (RETRY_CNT > 1) ? $clog2(RETRY_CNT) : 1;

  logic [MV_W-1:0]    thr_r [NUM_THR];
  logic [DLY_W-1:0]   delay_r;
  logic [EN_W-1:0]    en_r  [CONTROLLERS];
  logic [MV_W-1:0]    smp_r [CONTROLLERS][CHANNELS];
  logic               tripped_r;
  logic               armed_r;
  logic [DLY_W-1:0]   since_r;
  logic [CTRL_FW-1:0] it_ctrl_r;
  logic [CH_FW-1:0]   it_ch_r;
  logic [MV_W-1:0]    it_mv_r;
  logic [CH_W-1:0]    h_r;
  logic [RC_W-1:0]    c_r;
  logic               out_valid_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [CMD_W-1:0]   out_cmd_r;
  logic               out_last_r;

  logic [CTRL_FW-1:0] in_ctrl;
  logic [CH_FW-1:0]   in_ch;
  logic [MV_W-1:0]    in_mv;
  logic [CTRL_W-1:0]  ci;
  logic [CH_W-1:0]    hi;
  logic [CTRL_W-1:0]  ri;
  logic [EN_W-1:0]    en_clr;
  logic [EN_W-1:0]    scan_set;
  logic               load_chk;
  logic [CH_W-1:0]    h_nxt;

  assign in_ctrl = in_tdata[1:0];
  assign in_ch   = in_tdata[3:2];
  assign in_mv   = in_tdata[15:4];

  assign ci = CTRL_W'(it_ctrl_r);
  assign hi = CH_W'(it_ch_r);
  assign ri = CTRL_W'(c_r);

  assign en_clr   = en_r[ci] & ~(EN_W'(1) << it_ch_r);
  assign scan_set = (smp_r[ri][h_r] <= thr_r[2'(h_r)]) ? (EN_W'(1) << h_r) : '0;
  assign load_chk = cmd.chk_commit && sts.trip_hit;
  assign h_nxt    = sts.ch_last ? '0 : h_r + CH_W'(1);

  always_comb begin
    sts.idx_ok    = (32'(in_ctrl) < CONTROLLERS) && (32'(in_ch) < CHANNELS);
    sts.trip_hit  = armed_r && (it_mv_r > thr_r[it_ch_r]);
    sts.retry_due = tripped_r && (since_r >= delay_r);
    sts.ch_last   = (h_r == CH_W'(CHANNELS - 1));
    sts.ctrl_last = (c_r == RC_W'(RETRY_CNT - 1));
    sts.slot_free = !out_valid_r || out_tready;
  end

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r[0] <= THR0_RST;
      thr_r[1] <= THR1_RST;
      thr_r[2] <= THR2_RST;
      thr_r[3] <= THR3_RST;
      delay_r  <= DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THR0:  thr_r[0] <= cfg_wdata[MV_W-1:0];
        REG_THR1:  thr_r[1] <= cfg_wdata[MV_W-1:0];
        REG_THR2:  thr_r[2] <= cfg_wdata[MV_W-1:0];
        REG_THR3:  thr_r[3] <= cfg_wdata[MV_W-1:0];
        REG_DELAY: delay_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // fuse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CONTROLLERS; c++) begin
        en_r[c] <= EN_ALL;
        for (int h = 0; h < CHANNELS; h++) begin
          smp_r[c][h] <= '0;
        end
      end
      tripped_r <= 1'b0;
      armed_r   <= 1'b0;
      since_r   <= '0;
      h_r       <= '0;
      c_r       <= '0;
    end else begin
      if (cmd.chk_commit) begin
        smp_r[ci][hi] <= it_mv_r;
      end
      if (load_chk) begin
        en_r[ci]  <= en_clr;
        tripped_r <= 1'b1;
        since_r   <= '0;
      end
      if (cmd.tick && since_r != MS_MAX) begin
        since_r <= since_r + DLY_W'(1);
      end
      if (cmd.scan_start) begin
        armed_r <= 1'b1;
        h_r     <= '0;
        c_r     <= '0;
        if (sts.retry_due) tripped_r <= 1'b0;
      end
      if (cmd.scan_step) begin
        en_r[ri] <= en_r[ri] | scan_set;
        h_r      <= h_nxt;
      end
      if (cmd.emit) begin
        c_r <= c_r + RC_W'(1);
      end
    end
  end

  // latched check transaction
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      it_ctrl_r <= in_ctrl;
      it_ch_r   <= in_ch;
      it_mv_r   <= in_mv;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_chk || cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_chk) begin
      out_slot_r <= {1'b0, it_ctrl_r} + SLOT_W'(1);
      out_cmd_r  <= CMD_BASE | {{(CMD_W-EN_W){1'b0}}, en_clr};
      out_last_r <= 1'b1;
    end else if (cmd.emit) begin
      out_slot_r <= SLOT_W'(c_r) + SLOT_W'(1);
      out_cmd_r  <= CMD_BASE | {{(CMD_W-EN_W){1'b0}}, en_r[ri]};
      out_last_r <= sts.ctrl_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-CMD_W-SLOT_W){1'b0}}, out_cmd_r, out_slot_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTH
  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    (load_chk || cmd.emit) |-> (!out_valid_r || out_tready))
    else $error("command loaded over a stalled result");

  a_retry_clears_trip: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.scan_start && sts.retry_due) |=> !tripped_r)
    else $error("trip flag survived a retry");

  a_ms_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.tick && since_r == MS_MAX) |=> (since_r == MS_MAX))
    else $error("ms counter wrapped");

  a_out_well_formed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_slot_r != '0 && out_cmd_r[CMD_W-1]))
    else $error("malformed output command");
`endif

endmodule
